// File: rtl/potb_pkg.sv
// Shared types and operation codes for the periodic / one-shot task timer bank.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package potb_pkg;

    // operation code carried by each input item
    typedef logic [2:0] t_func;

    localparam t_func FN_TICK     = 3'd0;
    localparam t_func FN_ARM      = 3'd1;
    localparam t_func FN_JOIN     = 3'd2;
    localparam t_func FN_DROP     = 3'd3;
    localparam t_func FN_SET_CD   = 3'd4;
    localparam t_func FN_SET_PER  = 3'd5;
    localparam t_func FN_DISPATCH = 3'd6;
    localparam t_func FN_QUERY    = 3'd7;

    // fixed field widths of the item ports
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 16;
    localparam int JCNT_W  = 5;

    // most results one dispatch may report
    localparam int MAX_OUT = 16;
    localparam int RES_W   = 5;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [JCNT_W-1:0]  t_jcnt;
    typedef logic [RES_W-1:0]   t_rescnt;

endpackage

// File: rtl/potb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module potb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/periodic_oneshot_task_timer_bank_core.sv
// Periodic / one-shot task timer bank: countdown and period memories plus slot marks.
// Depends on potb_pkg and potb_ram.
// Arm, join, drop and set finish when accepted; a query reads in ST_QRD and answers
// from ST_QOUT when the output can take it; a tick counts down joined, nonzero slots.
// Dispatch scans one slot mark per cycle unless the output stalls, up to MAX_OUT results.
// One item at a time; the next item is accepted once the current one is finished.
// Reset (synchronous, active low) clears the marks, the count and the per-entry valid
// bits at once; entries never written read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps

module periodic_oneshot_task_timer_bank_core #(
    parameter int NUM_SLOTS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  potb_pkg::t_func  i_func,
    input  potb_pkg::t_slot  i_slot,
    input  potb_pkg::t_value i_value,
    input  logic             i_one_shot,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output potb_pkg::t_slot  o_ready_slot,
    output logic             o_found,
    output logic             o_last,
    output potb_pkg::t_value o_countdown,
    output potb_pkg::t_value o_period,
    output logic             o_joined,
    output potb_pkg::t_jcnt  o_joined_count
);

    import potb_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TICK  = 3'd1;
    localparam logic [2:0] ST_DISP  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_QRD   = 3'd4;
    localparam logic [2:0] ST_QOUT  = 3'd5;

    // control state
    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_rv, n_rv;
    logic [SW-1:0]        r_ridx, n_ridx;
    t_slot                r_slot, n_slot;
    logic                 r_held, n_held;
    t_slot                r_held_slot, n_held_slot;
    t_jcnt                r_held_cnt, n_held_cnt;
    t_rescnt              r_nres, n_nres;
    logic [NUM_SLOTS-1:0] r_pend, n_pend;
    logic [NUM_SLOTS-1:0] r_once, n_once;
    logic [NUM_SLOTS-1:0] r_join, n_join;
    logic [CW-1:0]        r_count, n_count;
    logic [NUM_SLOTS-1:0] r_cd_vld, n_cd_vld;
    logic [NUM_SLOTS-1:0] r_per_vld, n_per_vld;

    // output register
    logic   r_out_vld, n_out_vld;
    t_slot  r_out_slot, n_out_slot;
    logic   r_out_found, n_out_found;
    logic   r_out_last, n_out_last;
    t_value r_out_cd, n_out_cd;
    t_value r_out_per, n_out_per;
    logic   r_out_join, n_out_join;
    t_jcnt  r_out_cnt, n_out_cnt;

    // memory ports
    logic                   cd_we, per_we;
    logic [SW-1:0]          wr_addr, rd_addr;
    logic [COUNT_WIDTH-1:0] cd_wdata, per_wdata;
    logic [COUNT_WIDTH-1:0] cd_rdata, per_rdata;

    // helpers
    logic                   can_push;
    logic                   in_ok, q_ok;
    logic [SW-1:0]          in_addr, q_addr, d_addr;
    logic [COUNT_WIDTH-1:0] in_val, cd_cur, per_cur, cd_dec;
    logic [CW-1:0]          cnt_after;

    potb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SLOTS)) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (wr_addr),
        .i_wdata (cd_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cd_rdata)
    );

    potb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SLOTS)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (per_we),
        .i_waddr (wr_addr),
        .i_wdata (per_wdata),
        .i_raddr (rd_addr),
        .o_rdata (per_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign can_push   = !r_out_vld || i_out_ready;

    assign in_ok   = (int'(i_slot) < NUM_SLOTS);
    assign q_ok    = (int'(r_slot) < NUM_SLOTS);
    assign in_addr = SW'(i_slot);
    assign q_addr  = SW'(r_slot);
    assign d_addr  = r_idx[SW-1:0];
    assign in_val  = COUNT_WIDTH'(i_value);

    // read address: slot sweep during tick, addressed slot otherwise
    assign rd_addr = (r_state == ST_TICK) ? d_addr : q_addr;

    // read data, with never-written entries reading as zero
    assign cd_cur  = r_cd_vld[r_ridx] ? cd_rdata : '0;
    assign per_cur = r_per_vld[r_ridx] ? per_rdata : '0;
    assign cd_dec  = cd_cur - COUNT_WIDTH'(1);

    // sequencer and slot update
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rv        = 1'b0;
        n_ridx      = r_ridx;
        n_slot      = r_slot;
        n_held      = r_held;
        n_held_slot = r_held_slot;
        n_held_cnt  = r_held_cnt;
        n_nres      = r_nres;
        n_pend      = r_pend;
        n_once      = r_once;
        n_join      = r_join;
        n_count     = r_count;
        n_cd_vld    = r_cd_vld;
        n_per_vld   = r_per_vld;
        cnt_after   = r_count;

        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_slot  = r_out_slot;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        n_out_cd    = r_out_cd;
        n_out_per   = r_out_per;
        n_out_join  = r_out_join;
        n_out_cnt   = r_out_cnt;

        cd_we     = 1'b0;
        per_we    = 1'b0;
        wr_addr   = in_addr;
        cd_wdata  = in_val;
        per_wdata = in_val;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        FN_TICK: begin
                            n_idx   = '0;
                            n_state = ST_TICK;
                        end
                        FN_ARM: begin
                            if (in_ok) begin
                                cd_we              = 1'b1;
                                per_we             = 1'b1;
                                n_cd_vld[in_addr]  = 1'b1;
                                n_per_vld[in_addr] = 1'b1;
                                n_once[in_addr]    = i_one_shot;
                                n_pend[in_addr]    = 1'b0;
                            end
                        end
                        FN_JOIN: begin
                            if (in_ok && !r_join[in_addr]) begin
                                n_join[in_addr] = 1'b1;
                                n_count         = r_count + CW'(1);
                            end
                        end
                        FN_DROP: begin
                            if (in_ok && r_join[in_addr]) begin
                                n_join[in_addr] = 1'b0;
                                n_count         = r_count - CW'(1);
                            end
                        end
                        FN_SET_CD: begin
                            if (in_ok) begin
                                cd_we             = 1'b1;
                                n_cd_vld[in_addr] = 1'b1;
                            end
                        end
                        FN_SET_PER: begin
                            if (in_ok) begin
                                per_we             = 1'b1;
                                n_per_vld[in_addr] = 1'b1;
                            end
                        end
                        FN_DISPATCH: begin
                            n_idx   = '0;
                            n_held  = 1'b0;
                            n_nres  = '0;
                            n_state = ST_DISP;
                        end
                        FN_QUERY: begin
                            n_slot  = i_slot;
                            n_state = ST_QRD;
                        end
                    endcase
                end
            end

            ST_TICK: begin
                // issue the read of the next slot
                if (r_idx != CW'(NUM_SLOTS)) begin
                    n_rv   = 1'b1;
                    n_ridx = d_addr;
                    n_idx  = r_idx + CW'(1);
                end else if (!r_rv) begin
                    n_state = ST_IDLE;
                end
                // count down the slot read in the previous cycle
                if (r_rv && r_join[r_ridx] && (cd_cur != '0)) begin
                    cd_we            = 1'b1;
                    wr_addr          = r_ridx;
                    n_cd_vld[r_ridx] = 1'b1;
                    if (cd_dec == '0) begin
                        n_pend[r_ridx] = 1'b1;
                        cd_wdata       = per_cur;
                    end else begin
                        cd_wdata       = cd_dec;
                    end
                end
            end

            ST_DISP: begin
                if (r_idx == CW'(NUM_SLOTS)) begin
                    n_state = ST_FLUSH;
                end else if (r_join[d_addr] && r_pend[d_addr]) begin
                    if (!r_held || can_push) begin
                        // the earlier held item is not the last one
                        if (r_held) begin
                            n_out_vld   = 1'b1;
                            n_out_slot  = r_held_slot;
                            n_out_found = 1'b1;
                            n_out_last  = 1'b0;
                            n_out_cd    = '0;
                            n_out_per   = '0;
                            n_out_join  = 1'b0;
                            n_out_cnt   = r_held_cnt;
                        end
                        if (r_once[d_addr]) begin
                            cnt_after      = r_count - CW'(1);
                            n_join[d_addr] = 1'b0;
                        end
                        n_pend[d_addr] = 1'b0;
                        n_count        = cnt_after;
                        n_held         = 1'b1;
                        n_held_slot    = SLOT_W'(d_addr);
                        n_held_cnt     = JCNT_W'(cnt_after);
                        n_nres         = r_nres + RES_W'(1);
                        if (r_nres + RES_W'(1) == RES_W'(MAX_OUT)) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + CW'(1);
                        end
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            ST_FLUSH: begin
                if (can_push) begin
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_out_cd   = '0;
                    n_out_per  = '0;
                    n_out_join = 1'b0;
                    if (r_held) begin
                        n_out_slot  = r_held_slot;
                        n_out_found = 1'b1;
                        n_out_cnt   = r_held_cnt;
                    end else begin
                        n_out_slot  = '0;
                        n_out_found = 1'b0;
                        n_out_cnt   = JCNT_W'(r_count);
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_QRD: begin
                n_ridx  = q_addr;
                n_state = ST_QOUT;
            end

            ST_QOUT: begin
                n_ridx = r_ridx;
                if (can_push) begin
                    n_out_vld   = 1'b1;
                    n_out_slot  = r_slot;
                    n_out_found = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_cnt   = JCNT_W'(r_count);
                    if (q_ok) begin
                        n_out_cd   = VALUE_W'(cd_cur);
                        n_out_per  = VALUE_W'(per_cur);
                        n_out_join = r_join[q_addr];
                    end else begin
                        n_out_cd   = '0;
                        n_out_per  = '0;
                        n_out_join = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rv      <= 1'b0;
            r_held    <= 1'b0;
            r_pend    <= '0;
            r_once    <= '0;
            r_join    <= '0;
            r_count   <= '0;
            r_cd_vld  <= '0;
            r_per_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rv      <= n_rv;
            r_held    <= n_held;
            r_pend    <= n_pend;
            r_once    <= n_once;
            r_join    <= n_join;
            r_count   <= n_count;
            r_cd_vld  <= n_cd_vld;
            r_per_vld <= n_per_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload and index registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_ridx      <= n_ridx;
        r_slot      <= n_slot;
        r_held_slot <= n_held_slot;
        r_held_cnt  <= n_held_cnt;
        r_nres      <= n_nres;
        r_out_slot  <= n_out_slot;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
        r_out_cd    <= n_out_cd;
        r_out_per   <= n_out_per;
        r_out_join  <= n_out_join;
        r_out_cnt   <= n_out_cnt;
    end

    assign o_out_valid    = r_out_vld;
    assign o_ready_slot   = r_out_slot;
    assign o_found        = r_out_found;
    assign o_last         = r_out_last;
    assign o_countdown    = r_out_cd;
    assign o_period       = r_out_per;
    assign o_joined       = r_out_join;
    assign o_joined_count = r_out_cnt;

endmodule
